// ===== hw/rtl/fwst_pkg.sv =====
package fwst_pkg;

	// fixed port widths
	localparam int CMD_W     = 3;
	localparam int CHUNK_W   = 32;
	localparam int HANDLE_W  = 16;
	localparam int STATUS_W  = 3;
	localparam int CAP_W     = 5;

	// default geometry
	localparam int SLOTS_DEF       = 16;
	localparam int INDEX_BITS_DEF  = 32;
	localparam int HANDLE_BITS_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLAIM   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PUBLISH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] STS_MUST_FETCH = 3'd0;
	localparam logic [STATUS_W-1:0] STS_READY      = 3'd1;
	localparam logic [STATUS_W-1:0] STS_FETCHING   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FULL       = 3'd3;
	localparam logic [STATUS_W-1:0] STS_DONE       = 3'd4;
	localparam logic [STATUS_W-1:0] STS_IGNORED    = 3'd5;

	// update broadcast to the slot cells
	typedef enum logic [2:0] {
		APPLY_NONE,
		APPLY_SET_READY,
		APPLY_REMOVE,
		APPLY_INSERT,
		APPLY_ADVANCE,
		APPLY_CLEAR
	} apply_op_t;

	// flags of the scan record passed down the cell chain
	typedef struct packed {
		logic match;
		logic match_ready;
		logic victim_found;
		logic spot_found;
	} scan_flags_t;

endpackage

// ===== hw/rtl/fwst_cell.sv =====
module fwst_cell #(
	parameter int INDEX_BITS  = fwst_pkg::INDEX_BITS_DEF,
	parameter int HANDLE_BITS = fwst_pkg::HANDLE_BITS_DEF,
	parameter int POS         = 0,
	parameter int POS_W       = 1,
	parameter int CNT_W       = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// broadcast key and handle
	input  logic [INDEX_BITS-1:0]        key,
	input  logic [HANDLE_BITS-1:0]       hnd,
	// scan record from the previous cell
	input  fwst_pkg::scan_flags_t        flags_in,
	input  logic [HANDLE_BITS-1:0]       match_handle_in,
	input  logic [POS_W-1:0]             match_pos_in,
	input  logic [INDEX_BITS-1:0]        victim_index_in,
	input  logic [POS_W-1:0]             victim_pos_in,
	input  logic [POS_W-1:0]             spot_pos_in,
	input  logic [CNT_W-1:0]             used_in,
	// scan record to the next cell
	output fwst_pkg::scan_flags_t        flags_out,
	output logic [HANDLE_BITS-1:0]       match_handle_out,
	output logic [POS_W-1:0]             match_pos_out,
	output logic [INDEX_BITS-1:0]        victim_index_out,
	output logic [POS_W-1:0]             victim_pos_out,
	output logic [POS_W-1:0]             spot_pos_out,
	output logic [CNT_W-1:0]             used_out,
	// update
	input  fwst_pkg::apply_op_t          apply_op,
	input  logic [POS_W-1:0]             apply_pos
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

	logic                   valid_q;
	logic                   ready_q;
	logic [INDEX_BITS-1:0]  index_q;
	logic [HANDLE_BITS-1:0] handle_q;

	fwst_pkg::scan_flags_t  flags_q, flags_d;
	logic [HANDLE_BITS-1:0] match_handle_q, match_handle_d;
	logic [POS_W-1:0]       match_pos_q, match_pos_d;
	logic [INDEX_BITS-1:0]  victim_index_q, victim_index_d;
	logic [POS_W-1:0]       victim_pos_q, victim_pos_d;
	logic [POS_W-1:0]       spot_pos_q, spot_pos_d;
	logic [CNT_W-1:0]       used_q, used_d;

	logic hit;
	logic sel;

	assign hit = valid_q && (index_q == key);
	assign sel = (apply_pos == MY_POS);

	// fold this slot into the scan record
	always_comb begin
		flags_d        = flags_in;
		match_handle_d = match_handle_in;
		match_pos_d    = match_pos_in;
		victim_index_d = victim_index_in;
		victim_pos_d   = victim_pos_in;
		spot_pos_d     = spot_pos_in;
		used_d         = used_in + CNT_W'(valid_q);
		if (hit && !flags_in.match) begin
			flags_d.match       = 1'b1;
			flags_d.match_ready = ready_q;
			match_handle_d      = handle_q;
			match_pos_d         = MY_POS;
		end
		if (!valid_q && !flags_in.spot_found) begin
			flags_d.spot_found = 1'b1;
			spot_pos_d         = MY_POS;
		end
		if (valid_q && ready_q &&
				(!flags_in.victim_found || (index_q < victim_index_in))) begin
			flags_d.victim_found = 1'b1;
			victim_index_d       = index_q;
			victim_pos_d         = MY_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		match_handle_q <= match_handle_d;
		match_pos_q    <= match_pos_d;
		victim_index_q <= victim_index_d;
		victim_pos_q   <= victim_pos_d;
		spot_pos_q     <= spot_pos_d;
		used_q         <= used_d;
	end

	assign flags_out        = flags_q;
	assign match_handle_out = match_handle_q;
	assign match_pos_out    = match_pos_q;
	assign victim_index_out = victim_index_q;
	assign victim_pos_out   = victim_pos_q;
	assign spot_pos_out     = spot_pos_q;
	assign used_out         = used_q;

	// slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ready_q <= 1'b0;
		end else begin
			case (apply_op)
				fwst_pkg::APPLY_SET_READY: begin
					if (sel) begin
						ready_q <= 1'b1;
					end
				end
				fwst_pkg::APPLY_REMOVE: begin
					if (sel) begin
						valid_q <= 1'b0;
						ready_q <= 1'b0;
					end
				end
				fwst_pkg::APPLY_INSERT: begin
					if (sel) begin
						valid_q <= 1'b1;
						ready_q <= 1'b0;
					end
				end
				fwst_pkg::APPLY_ADVANCE: begin
					if (valid_q && (index_q < key)) begin
						valid_q <= 1'b0;
						ready_q <= 1'b0;
					end
				end
				fwst_pkg::APPLY_CLEAR: begin
					valid_q <= 1'b0;
					ready_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (sel && (apply_op == fwst_pkg::APPLY_SET_READY)) begin
			handle_q <= hnd;
		end
		if (sel && (apply_op == fwst_pkg::APPLY_INSERT)) begin
			index_q  <= key;
			handle_q <= '0;
		end
	end

endmodule

// ===== hw/rtl/fetch_window_slot_table_unit.sv =====
// a request is captured in idle, its scan record then passes through the register of every cell,
// and the result is loaded into the output register from the finish state; no new request is taken until then
// a new request is taken while the previous result still waits at the output register
// reset: asynchronous, active low; all slots empty, capacity 16, no result pending
module fetch_window_slot_table_unit #(
	parameter int SLOTS       = fwst_pkg::SLOTS_DEF,
	parameter int INDEX_BITS  = fwst_pkg::INDEX_BITS_DEF,
	parameter int HANDLE_BITS = fwst_pkg::HANDLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fwst_pkg::CAP_W-1:0]      cfg_data,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fwst_pkg::CMD_W-1:0]      command,
	input  logic [fwst_pkg::CHUNK_W-1:0]    chunk_index,
	input  logic [fwst_pkg::HANDLE_W-1:0]   data_handle,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fwst_pkg::STATUS_W-1:0]   status,
	output logic                            ready_res,
	output logic [fwst_pkg::HANDLE_W-1:0]   handle_out
);

	localparam int POS_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int CAP_W   = fwst_pkg::CAP_W;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int HOUT_W  = fwst_pkg::HANDLE_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	// request latched for the whole scan
	logic [fwst_pkg::CMD_W-1:0] cmd_q;
	logic [INDEX_BITS-1:0]      idx_q;
	logic [HANDLE_BITS-1:0]     hnd_q;
	logic [POS_W-1:0]           scan_cnt_q;

	logic [CAP_W-1:0]           capacity_q;

	// output register
	logic                       out_valid_q;
	logic [fwst_pkg::STATUS_W-1:0] status_q;
	logic                       ready_res_q;
	logic [HOUT_W-1:0]          handle_out_q;

	// scan record chain, one link per cell plus the head
	fwst_pkg::scan_flags_t  flags_c        [SLOTS+1];
	logic [HANDLE_BITS-1:0] match_handle_c [SLOTS+1];
	logic [POS_W-1:0]       match_pos_c    [SLOTS+1];
	logic [INDEX_BITS-1:0]  victim_index_c [SLOTS+1];
	logic [POS_W-1:0]       victim_pos_c   [SLOTS+1];
	logic [POS_W-1:0]       spot_pos_c     [SLOTS+1];
	logic [CNT_W-1:0]       used_c         [SLOTS+1];

	fwst_pkg::apply_op_t    apply_op;
	logic [POS_W-1:0]       apply_pos;

	// decision taken at the end of the scan
	logic [fwst_pkg::STATUS_W-1:0] dec_status;
	logic                          dec_ready;
	logic [HOUT_W-1:0]             dec_handle;
	fwst_pkg::apply_op_t           dec_op;
	logic [POS_W-1:0]              dec_pos;

	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] used_ext;
	logic             at_capacity;
	logic             finish_go;

	// config register, always writable (the host must write it only while idle; the block does not enforce this)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= fwst_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	// head of the chain starts with an empty record
	assign flags_c[0]        = '0;
	assign match_handle_c[0] = '0;
	assign match_pos_c[0]    = '0;
	assign victim_index_c[0] = '0;
	assign victim_pos_c[0]   = '0;
	assign spot_pos_c[0]     = '0;
	assign used_c[0]         = '0;

	// one cell per slot; each registers the record and hands it on
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		fwst_cell #(
			.INDEX_BITS  (INDEX_BITS),
			.HANDLE_BITS (HANDLE_BITS),
			.POS         (g),
			.POS_W       (POS_W),
			.CNT_W       (CNT_W)
		) u_cell (
			.clk              (clk),
			.arst_n           (arst_n),
			.key              (idx_q),
			.hnd              (hnd_q),
			.flags_in         (flags_c[g]),
			.match_handle_in  (match_handle_c[g]),
			.match_pos_in     (match_pos_c[g]),
			.victim_index_in  (victim_index_c[g]),
			.victim_pos_in    (victim_pos_c[g]),
			.spot_pos_in      (spot_pos_c[g]),
			.used_in          (used_c[g]),
			.flags_out        (flags_c[g+1]),
			.match_handle_out (match_handle_c[g+1]),
			.match_pos_out    (match_pos_c[g+1]),
			.victim_index_out (victim_index_c[g+1]),
			.victim_pos_out   (victim_pos_c[g+1]),
			.spot_pos_out     (spot_pos_c[g+1]),
			.used_out         (used_c[g+1]),
			.apply_op         (apply_op),
			.apply_pos        (apply_pos)
		);
	end

	// effective capacity is min(capacity, SLOTS)
	always_comb begin
		cap_eff = CMP_W'(capacity_q);
		if (cap_eff > CMP_W'(SLOTS)) begin
			cap_eff = CMP_W'(SLOTS);
		end
	end

	assign used_ext    = CMP_W'(used_c[SLOTS]);
	assign at_capacity = (used_ext >= cap_eff);

	// result and update from the completed scan record
	always_comb begin
		dec_status = fwst_pkg::STS_IGNORED;
		dec_ready  = 1'b0;
		dec_handle = '0;
		dec_op     = fwst_pkg::APPLY_NONE;
		dec_pos    = '0;
		case (cmd_q)
			fwst_pkg::CMD_LOOKUP: begin
				if (flags_c[SLOTS].match) begin
					if (flags_c[SLOTS].match_ready) begin
						dec_status = fwst_pkg::STS_READY;
						dec_ready  = 1'b1;
						dec_handle = HOUT_W'(match_handle_c[SLOTS]);
					end else begin
						dec_status = fwst_pkg::STS_FETCHING;
					end
				end
			end
			fwst_pkg::CMD_CLAIM: begin
				if (flags_c[SLOTS].match) begin
					dec_status = flags_c[SLOTS].match_ready ? fwst_pkg::STS_READY
						: fwst_pkg::STS_FETCHING;
				end else if (at_capacity) begin
					// evict the ready slot with the smallest index
					if (flags_c[SLOTS].victim_found) begin
						dec_status = fwst_pkg::STS_MUST_FETCH;
						dec_op     = fwst_pkg::APPLY_INSERT;
						dec_pos    = victim_pos_c[SLOTS];
					end else begin
						dec_status = fwst_pkg::STS_FULL;
					end
				end else if (flags_c[SLOTS].spot_found) begin
					dec_status = fwst_pkg::STS_MUST_FETCH;
					dec_op     = fwst_pkg::APPLY_INSERT;
					dec_pos    = spot_pos_c[SLOTS];
				end else begin
					dec_status = fwst_pkg::STS_FULL;
				end
			end
			fwst_pkg::CMD_PUBLISH: begin
				if (flags_c[SLOTS].match) begin
					dec_status = fwst_pkg::STS_DONE;
					dec_op     = fwst_pkg::APPLY_SET_READY;
					dec_pos    = match_pos_c[SLOTS];
				end
			end
			fwst_pkg::CMD_CANCEL: begin
				// only a fetching entry may be dropped
				if (flags_c[SLOTS].match && !flags_c[SLOTS].match_ready) begin
					dec_status = fwst_pkg::STS_DONE;
					dec_op     = fwst_pkg::APPLY_REMOVE;
					dec_pos    = match_pos_c[SLOTS];
				end
			end
			fwst_pkg::CMD_ADVANCE: begin
				dec_status = fwst_pkg::STS_DONE;
				dec_op     = fwst_pkg::APPLY_ADVANCE;
			end
			fwst_pkg::CMD_CLEAR: begin
				dec_status = fwst_pkg::STS_DONE;
				dec_op     = fwst_pkg::APPLY_CLEAR;
			end
			default: begin
			end
		endcase
	end

	// finish once the output register can take the result
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// update goes to the cells in the same cycle the result is loaded
	assign apply_op  = finish_go ? dec_op : fwst_pkg::APPLY_NONE;
	assign apply_pos = dec_pos;

	assign in_ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_SCAN;
						scan_cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					// stay here until the record has passed through every cell to the tail
					if (scan_cnt_q == POS_W'(SLOTS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			idx_q <= INDEX_BITS'(chunk_index);
			hnd_q <= HANDLE_BITS'(data_handle);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			status_q     <= dec_status;
			ready_res_q  <= dec_ready;
			handle_out_q <= dec_handle;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign ready_res  = ready_res_q;
	assign handle_out = handle_out_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int CMD_W    = fwst_pkg::CMD_W;
	localparam int CHUNK_W  = fwst_pkg::CHUNK_W;
	localparam int HANDLE_W = fwst_pkg::HANDLE_W;
	localparam int STATUS_W = fwst_pkg::STATUS_W;
	localparam int CAP_W    = fwst_pkg::CAP_W;

	localparam int NUM_SLOTS    = fwst_pkg::SLOTS_DEF;
	// a slot scan walks the whole cell chain and random stalls lengthen the wait
	localparam int QUIET_LIMIT  = 2000;
	// settle time once nothing is expected any more
	localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 4;
	localparam int IDLE_PCT     = 27;
	localparam int PHASE_ITEMS  = 177;

	// command values the block must ignore
	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [CHUNK_W-1:0]  chunk_index;
		logic [HANDLE_W-1:0] data_handle;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                ready_res;
		logic [HANDLE_W-1:0] handle_out;
	} result_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #10 clk = ~clk;

	// block inputs, known from time zero
	logic                cfg_valid   = 1'b0;
	logic [CAP_W-1:0]    cfg_data    = '0;
	logic                in_valid    = 1'b0;
	logic [CMD_W-1:0]    command     = fwst_pkg::CMD_LOOKUP;
	logic [CHUNK_W-1:0]  chunk_index = '0;
	logic [HANDLE_W-1:0] data_handle = '0;
	logic                out_ready   = 1'b0;

	// block outputs
	logic                cfg_ready;
	logic                in_ready;
	logic                out_valid;
	logic [STATUS_W-1:0] status;
	logic                ready_res;
	logic [HANDLE_W-1:0] handle_out;

	fetch_window_slot_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.chunk_index(chunk_index),
		.data_handle(data_handle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.ready_res  (ready_res),
		.handle_out (handle_out)
	);

	// requests waiting to be driven, front one is on the bus once shown
	request_t req_backlog [$];
	// answers owed by the block, oldest first
	result_t  status_due [$];

	logic req_on_bus = 1'b0;
	// no random idling on either side while set
	logic calm       = 1'b0;
	int   fail_count = 0;
	int   quiet_cycles = 0;

	// shadow copy of the slot table
	logic                tbl_valid  [NUM_SLOTS];
	logic                tbl_ready  [NUM_SLOTS];
	logic [CHUNK_W-1:0]  tbl_index  [NUM_SLOTS];
	logic [HANDLE_W-1:0] tbl_handle [NUM_SLOTS];
	logic [CAP_W-1:0]    tbl_capacity = fwst_pkg::CAP_RESET;

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			tbl_valid[i]  = 1'b0;
			tbl_ready[i]  = 1'b0;
			tbl_index[i]  = '0;
			tbl_handle[i] = '0;
		end
	end

	function automatic int find_slot(input logic [CHUNK_W-1:0] idx);
		for (int i = 0; i < NUM_SLOTS; i++)
			if (tbl_valid[i] && tbl_index[i] == idx)
				return i;
		return -1;
	endfunction

	// claim: report a present entry, else insert, evicting the lowest ready index if full
	function automatic logic [STATUS_W-1:0] claim_slot(input logic [CHUNK_W-1:0] idx);
		int hit;
		int victim;
		int spot;
		int used;
		int cap;
		hit = find_slot(idx);
		if (hit >= 0)
			return tbl_ready[hit] ? fwst_pkg::STS_READY : fwst_pkg::STS_FETCHING;
		victim = -1;
		spot   = -1;
		used   = 0;
		// capacity above the slot count acts as the slot count
		cap = (tbl_capacity > NUM_SLOTS) ? NUM_SLOTS : int'(tbl_capacity);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (tbl_valid[i])
				used++;
			else if (spot < 0)
				spot = i;
		end
		// at or over capacity: exactly one ready entry makes room
		if (used >= cap) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				if (tbl_valid[i] && tbl_ready[i] &&
						(victim < 0 || tbl_index[i] < tbl_index[victim]))
					victim = i;
			if (victim < 0)
				return fwst_pkg::STS_FULL;
			tbl_valid[victim] = 1'b0;
			tbl_ready[victim] = 1'b0;
			spot = victim;
		end
		if (spot < 0)
			return fwst_pkg::STS_FULL;
		tbl_valid[spot]  = 1'b1;
		tbl_ready[spot]  = 1'b0;
		tbl_index[spot]  = idx;
		tbl_handle[spot] = '0;
		return fwst_pkg::STS_MUST_FETCH;
	endfunction

	// applies one request to the shadow table and returns the answer it owes
	function automatic result_t table_apply(input request_t rq);
		result_t res;
		int hit;
		res.status     = fwst_pkg::STS_IGNORED;
		res.ready_res  = 1'b0;
		res.handle_out = '0;
		hit = find_slot(rq.chunk_index);
		case (rq.command)
		fwst_pkg::CMD_LOOKUP: begin
			if (hit >= 0 && tbl_ready[hit]) begin
				res.status     = fwst_pkg::STS_READY;
				res.ready_res  = 1'b1;
				res.handle_out = tbl_handle[hit];
			end else if (hit >= 0)
				res.status = fwst_pkg::STS_FETCHING;
		end
		fwst_pkg::CMD_CLAIM: res.status = claim_slot(rq.chunk_index);
		fwst_pkg::CMD_PUBLISH: begin
			// fetching or already ready, the handle is replaced either way
			if (hit >= 0) begin
				tbl_ready[hit]  = 1'b1;
				tbl_handle[hit] = rq.data_handle;
				res.status      = fwst_pkg::STS_DONE;
			end
		end
		fwst_pkg::CMD_CANCEL: begin
			// only a fetching entry can be dropped
			if (hit >= 0 && !tbl_ready[hit]) begin
				tbl_valid[hit] = 1'b0;
				res.status     = fwst_pkg::STS_DONE;
			end
		end
		fwst_pkg::CMD_ADVANCE: begin
			for (int i = 0; i < NUM_SLOTS; i++)
				if (tbl_valid[i] && tbl_index[i] < rq.chunk_index) begin
					tbl_valid[i] = 1'b0;
					tbl_ready[i] = 1'b0;
				end
			res.status = fwst_pkg::STS_DONE;
		end
		fwst_pkg::CMD_CLEAR: begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				tbl_valid[i] = 1'b0;
				tbl_ready[i] = 1'b0;
			end
			res.status = fwst_pkg::STS_DONE;
		end
		default: ;
		endcase
		return res;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// request driver: new values only at the falling edge
	always @(negedge clk) begin
		if (arst_n && !req_on_bus) begin
			if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				command     <= req_backlog[0].command;
				chunk_index <= req_backlog[0].chunk_index;
				data_handle <= req_backlog[0].data_handle;
				in_valid    <= 1'b1;
				req_on_bus  = 1'b1;
			end else
				in_valid <= 1'b0;
		end
		// result side back-pressure
		out_ready <= arst_n && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	// accept and check at the rising edge
	always @(posedge clk) begin : accept_and_check
		result_t  got;
		result_t  want;
		request_t taken;
		// results first: one leaving now cannot belong to a request taken now
		if (arst_n && out_valid && out_ready) begin
			got.status     = status;
			got.ready_res  = ready_res;
			got.handle_out = handle_out;
			if (status_due.size() == 0)
				note_failure($sformatf("unexpected result: status %0d ready_res %0b handle_out %h",
					got.status, got.ready_res, got.handle_out));
			else begin
				want = status_due.pop_front();
				if (got.status !== want.status || got.ready_res !== want.ready_res ||
						got.handle_out !== want.handle_out)
					note_failure($sformatf({"mismatch: status %0d/%0d ready_res %0b/%0b ",
						"handle_out %h/%h (expected/actual)"},
						want.status, got.status, want.ready_res, got.ready_res,
						want.handle_out, got.handle_out));
			end
		end
		if (arst_n && in_valid && in_ready) begin
			taken = req_backlog.pop_front();
			status_due = {status_due, table_apply(taken)};
			req_on_bus = 1'b0;
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else if (++quiet_cycles >= QUIET_LIMIT) begin
			$display("fetch_window_slot_table_unit test failed");
			$finish;
		end
	end

	task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [CHUNK_W-1:0] idx,
			input logic [HANDLE_W-1:0] hnd);
		request_t rq;
		rq.command     = cmd;
		rq.chunk_index = idx;
		rq.data_handle = hnd;
		req_backlog = {req_backlog, rq};
	endtask

	// waits until every queued request is sent and every owed result is back, then lets the block settle
	task automatic wait_drained();
		while (req_backlog.size() != 0 || status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// capacity write, only issued while the block is idle
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tbl_capacity = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hand-picked requests on an empty table at full capacity
	task automatic queue_directed();
		// lookup of an absent index
		push_req(fwst_pkg::CMD_LOOKUP, 32'h0, 16'h0);
		// claim new, claim again while fetching, lookup while fetching
		push_req(fwst_pkg::CMD_CLAIM, 32'h0, 16'hFFFF);
		push_req(fwst_pkg::CMD_CLAIM, 32'h0, 16'h0);
		push_req(fwst_pkg::CMD_LOOKUP, 32'h0, 16'h0);
		// publish, then lookup and claim of a ready entry
		push_req(fwst_pkg::CMD_PUBLISH, 32'h0, 16'hFFFF);
		push_req(fwst_pkg::CMD_LOOKUP, 32'h0, 16'h0);
		push_req(fwst_pkg::CMD_CLAIM, 32'h0, 16'h0);
		// cancel of a ready entry is refused
		push_req(fwst_pkg::CMD_CANCEL, 32'h0, 16'h0);
		// cancel while fetching, then cancel of the now absent index
		push_req(fwst_pkg::CMD_CLAIM, 32'hFFFF_FFFF, 16'h0);
		push_req(fwst_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 16'h0);
		push_req(fwst_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 16'hFFFF);
		// publish of an absent index
		push_req(fwst_pkg::CMD_PUBLISH, 32'h5555_5555, 16'hAAAA);
		// publish twice, the second handle wins
		push_req(fwst_pkg::CMD_CLAIM, 32'hAAAA_AAAA, 16'h0);
		push_req(fwst_pkg::CMD_PUBLISH, 32'hAAAA_AAAA, 16'h5555);
		push_req(fwst_pkg::CMD_PUBLISH, 32'hAAAA_AAAA, 16'h0001);
		push_req(fwst_pkg::CMD_LOOKUP, 32'hAAAA_AAAA, 16'h0);
		// advance to zero drops nothing
		push_req(fwst_pkg::CMD_ADVANCE, 32'h0, 16'h0);
		push_req(fwst_pkg::CMD_LOOKUP, 32'h0, 16'h0);
		// advance past both entries
		push_req(fwst_pkg::CMD_ADVANCE, 32'hAAAA_AAAB, 16'h0);
		push_req(fwst_pkg::CMD_LOOKUP, 32'hAAAA_AAAA, 16'h0);
		// unused command codes
		push_req(CMD_SPARE_A, 32'h0, 16'hFFFF);
		push_req(CMD_SPARE_B, 32'hFFFF_FFFF, 16'h0);
		// advance to the top index keeps only the top index, then clear empties the table
		push_req(fwst_pkg::CMD_CLAIM, 32'h1, 16'h0);
		push_req(fwst_pkg::CMD_CLAIM, 32'hFFFF_FFFF, 16'h0);
		push_req(fwst_pkg::CMD_ADVANCE, 32'hFFFF_FFFF, 16'h0);
		push_req(fwst_pkg::CMD_CLEAR, 32'h0, 16'h0);
		push_req(fwst_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0);
	endtask

	// fetch-window traffic: indices from a sliding window so claims, publishes
	// and evictions keep meeting each other, plus a little noise
	task automatic queue_window_traffic(input int count);
		logic [CHUNK_W-1:0] base;
		logic [CHUNK_W-1:0] idx;
		int span;
		int pick;
		case ($urandom_range(3))
		0: base = $urandom_range(8);
		1: base = 32'hFFFF_FFFF - $urandom_range(40);
		default: base = $urandom;
		endcase
		// window width against capacity decides how often eviction is needed
		span = $urandom_range(24, 6);
		for (int n = 0; n < count; n++) begin
			idx  = base + $urandom_range(span);
			pick = $urandom_range(99);
			if (pick < 34)
				push_req(fwst_pkg::CMD_CLAIM, idx, 16'($urandom));
			else if (pick < 54)
				push_req(fwst_pkg::CMD_PUBLISH, idx, 16'($urandom));
			else if (pick < 72)
				push_req(fwst_pkg::CMD_LOOKUP, idx, 16'($urandom));
			else if (pick < 82)
				push_req(fwst_pkg::CMD_CANCEL, idx, 16'($urandom));
			else if (pick < 89) begin
				// slide the window forward
				base = base + $urandom_range(span / 3);
				push_req(fwst_pkg::CMD_ADVANCE, base, 16'($urandom));
			end else if (pick < 91)
				push_req(fwst_pkg::CMD_CLEAR, $urandom, 16'($urandom));
			else if (pick < 93)
				push_req($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B, $urandom, 16'($urandom));
			else
				push_req(CMD_W'($urandom_range(fwst_pkg::CMD_ADVANCE, fwst_pkg::CMD_LOOKUP)),
					$urandom, 16'($urandom));
		end
	endtask

	// run sequence
	initial begin
		logic [CAP_W-1:0] cap_plan [$];
		// over the slot count, then lowered with entries still in place, then zero, then a mix and a random value
		cap_plan = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd4, 5'd2, 5'd16, 5'd15, 5'd8};
		cap_plan = {cap_plan, CAP_W'($urandom_range(31))};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_capacity(fwst_pkg::CAP_RESET);
		queue_directed();
		wait_drained();

		foreach (cap_plan[p]) begin
			write_capacity(cap_plan[p]);
			// one phase with no idling on either side
			calm = (p == 6);
			queue_window_traffic(PHASE_ITEMS);
			wait_drained();
			calm = 1'b0;
		end

		if (fail_count == 0)
			$display("fetch_window_slot_table_unit test passed");
		else
			$display("fetch_window_slot_table_unit test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/fwst_pkg.sv
hw/rtl/fwst_cell.sv
hw/rtl/fetch_window_slot_table_unit.sv
tb/sv/tb.sv
